@@ rtl/core/msf_pkg.sv @@
`default_nettype none

package msf_pkg;

    // Widths of the item fields.
    localparam int CHAR_W    = 8;
    localparam int SEQ_OUT_W = 16;
    localparam int POS_OUT_W = 32;
    localparam int GAP_W     = 16;

    // Default sizes of the position and sequence counters.
    localparam int POS_BITS_DEF = 32;
    localparam int SEQ_BITS_DEF = 16;

    // Register port geometry: one 32-bit register at byte address 0.
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REG_SEL_W = PADDR_W - 2;
    localparam logic [REG_SEL_W-1:0] REG_GAP_THRESHOLD = '0;

    // Masked base characters.
    localparam logic [CHAR_W-1:0] CHAR_N_UP = 8'h4E;
    localparam logic [CHAR_W-1:0] CHAR_N_LO = 8'h6E;
    localparam logic [CHAR_W-1:0] CHAR_X_UP = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_X_LO = 8'h78;

    // Result handed from the scan stage to the output register.
    typedef struct packed {
        logic                 fire;
        logic [SEQ_OUT_W-1:0] sequence_number;
        logic [POS_OUT_W-1:0] stretch_start;
        logic [POS_OUT_W-1:0] stretch_end;
    } t_msf_res;

    function automatic logic is_masked(input logic [CHAR_W-1:0] c);
        return (c == CHAR_N_UP) || (c == CHAR_N_LO) ||
               (c == CHAR_X_UP) || (c == CHAR_X_LO);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/msf_if.sv @@
`default_nettype none

// Channel carrying sequence characters into the block.
interface msf_in_if import msf_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] base_char;
    logic              last_of_sequence;

    modport source(output valid, base_char, last_of_sequence, input ready);
    modport sink(input valid, base_char, last_of_sequence, output ready);
endinterface

// Channel carrying reported stretches out of the block.
interface msf_out_if import msf_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [SEQ_OUT_W-1:0] sequence_number;
    logic [POS_OUT_W-1:0] stretch_start;
    logic [POS_OUT_W-1:0] stretch_end;

    modport source(output valid, sequence_number, stretch_start, stretch_end, input ready);
    modport sink(input valid, sequence_number, stretch_start, stretch_end, output ready);
endinterface

`default_nettype wire

@@ rtl/core/msf_cfg.sv @@
`default_nettype none

module msf_cfg import msf_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [GAP_W-1:0]   o_gap_threshold
);

    logic [GAP_W-1:0]     r_gap;
    logic [REG_SEL_W-1:0] reg_sel;
    logic                 wr_en;

    // Word select ignores the byte offset bits.
    assign reg_sel = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && (reg_sel == REG_GAP_THRESHOLD);
    assign pready  = 1'b1;

    // Gap threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
        end else if (wr_en) begin
            r_gap <= pwdata[GAP_W-1:0];
        end
    end

    // Read back.
    always_comb begin
        prdata = '0;
        if (reg_sel == REG_GAP_THRESHOLD) begin
            prdata = PDATA_W'(r_gap);
        end
    end

    assign o_gap_threshold = r_gap;

endmodule

`default_nettype wire

@@ rtl/core/msf_scan.sv @@
`default_nettype none

module msf_scan import msf_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int SEQ_BITS = SEQ_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [GAP_W-1:0]  i_gap_threshold,
    input  wire logic              i_valid,
    input  wire logic [CHAR_W-1:0] i_base_char,
    input  wire logic              i_last,
    input  wire logic              i_out_free,
    output logic                   o_ready,
    output t_msf_res               o_res
);

    localparam int CMP_W = POS_BITS + GAP_W;

    // Input register.
    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    // Per-sequence state.
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [POS_BITS-1:0] r_run_begin, n_run_begin;
    logic [POS_BITS-1:0] r_last_end, n_last_end;
    logic [POS_BITS-1:0] r_total, n_total;
    logic [SEQ_BITS-1:0] r_seq;

    logic                consume;
    logic                gap_on;
    logic                masked;
    logic [POS_BITS-1:0] gap_dist;
    logic                gap_big;
    logic                gap_emit;
    logic                end_emit;

    assign consume = r_valid && i_out_free;
    assign o_ready = !r_valid || consume;

    // Capture incoming items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_base_char;
            r_last <= i_last;
        end
    end

    // Step logic for the item in the input register.
    always_comb begin
        gap_on   = (i_gap_threshold != '0);
        masked   = is_masked(r_char);
        gap_dist = r_pos - r_last_end;
        gap_big  = CMP_W'(gap_dist) > CMP_W'(i_gap_threshold);

        n_run_begin = r_run_begin;
        n_total     = r_total;
        n_last_end  = r_last_end;
        gap_emit    = 1'b0;

        if (gap_on && masked) begin
            if (r_total == '0) begin
                n_run_begin = r_pos;
            end
            if (r_total != '1) begin
                n_total = r_total + 1'b1;
            end
            n_last_end = r_pos + 1'b1;
        end else if (gap_on && gap_big) begin
            gap_emit = CMP_W'(r_total) > CMP_W'(i_gap_threshold);
            n_total  = '0;
        end

        end_emit = r_last && !gap_emit && gap_on &&
                   (CMP_W'(n_total) > CMP_W'(i_gap_threshold));
        n_pos    = r_pos + 1'b1;
    end

    // Result built from the updated stretch bounds.
    assign o_res.fire            = consume && (gap_emit || end_emit);
    assign o_res.sequence_number = SEQ_OUT_W'(r_seq);
    assign o_res.stretch_start   = POS_OUT_W'(POS_BITS'(n_run_begin + 1'b1));
    assign o_res.stretch_end     = POS_OUT_W'(n_last_end);

    // State update; the last character clears the sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_run_begin <= '0;
            r_last_end  <= '0;
            r_total     <= '0;
            r_seq       <= '0;
        end else if (consume) begin
            if (r_last) begin
                r_pos       <= '0;
                r_run_begin <= '0;
                r_last_end  <= '0;
                r_total     <= '0;
                r_seq       <= r_seq + 1'b1;
            end else begin
                r_pos       <= n_pos;
                r_run_begin <= n_run_begin;
                r_last_end  <= n_last_end;
                r_total     <= n_total;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/masked_base_stretch_finder_top.sv @@
// Masked base stretch finder.
// Characters arrive on i_in, one item per character, with last_of_sequence
// set on the final character of each sequence. Runs of N, n, X and x that lie
// within gap_threshold characters of each other form one stretch; a stretch
// whose masked count exceeds gap_threshold leaves on o_out as an item with
// its sequence number and 1-based first and last masked positions.
// gap_threshold is written over the APB port at byte address 0; zero turns
// detection off while positions and sequence numbers still advance.
// Throughput is one character per cycle while o_out is not stalled. An item
// passes an input register and the scan logic into the output register, from
// which its result leaves. At most one result comes from each character.
// When the receiver stalls, a held result keeps the scan stage from taking
// the next character, and i_in.ready drops once the input register is full.
// Reset clears the threshold, positions, counts and the sequence number,
// and empties both registers.
`default_nettype none

module masked_base_stretch_finder_top import msf_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int SEQ_BITS = SEQ_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    msf_in_if.sink                  i_in,
    msf_out_if.source               o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic [GAP_W-1:0]     gap_threshold;
    logic                 out_free;
    t_msf_res             res;
    logic                 r_out_valid;
    logic [SEQ_OUT_W-1:0] r_seq_num;
    logic [POS_OUT_W-1:0] r_start;
    logic [POS_OUT_W-1:0] r_end;

    msf_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_gap_threshold (gap_threshold)
    );

    msf_scan #(
        .POS_BITS (POS_BITS),
        .SEQ_BITS (SEQ_BITS)
    ) u_scan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_gap_threshold (gap_threshold),
        .i_valid         (i_in.valid),
        .i_base_char     (i_in.base_char),
        .i_last          (i_in.last_of_sequence),
        .i_out_free      (out_free),
        .o_ready         (i_in.ready),
        .o_res           (res)
    );

    // Output register.
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.fire) begin
            r_seq_num <= res.sequence_number;
            r_start   <= res.stretch_start;
            r_end     <= res.stretch_end;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.sequence_number = r_seq_num;
    assign o_out.stretch_start   = r_start;
    assign o_out.stretch_end     = r_end;

`ifndef SYNTHESIS
    // A new result never overwrites one still waiting at the output.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res.fire && r_out_valid && !o_out.ready))
        else $error("result overwrote a pending output item");

    // With detection off nothing is reported.
    a_off_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.fire |-> (gap_threshold != '0))
        else $error("result produced while detection is off");

    // The output is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire
